@@ hdl/vbib_pkg.sv @@
// ----------------------------------------------------------------------------
// vbib_pkg
// shared types, widths and register codes for the view box to image box block
// ----------------------------------------------------------------------------
package vbib_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int VIEW_W  = 16;
  localparam int DIM_W   = 15;
  localparam int COEF_W  = 24;
  localparam int TRANS_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  // widened corner coordinate: left - 1 up to left + width
  localparam int PIX_W  = VIEW_W + 2;
  localparam int PROD_W = COEF_W + PIX_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_COEF_YX  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_TRANS_X  = 3'd4,
    REG_TRANS_Y  = 3'd5,
    REG_IMAGE_W  = 3'd6,
    REG_IMAGE_H  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_xx;
    logic signed [COEF_W-1:0]  coef_xy;
    logic signed [COEF_W-1:0]  coef_yx;
    logic signed [COEF_W-1:0]  coef_yy;
    logic signed [TRANS_W-1:0] trans_x;
    logic signed [TRANS_W-1:0] trans_y;
    logic        [DIM_W-1:0]   image_width;
    logic        [DIM_W-1:0]   image_height;
  } cfg_t;

  typedef struct packed {
    logic signed [VIEW_W-1:0] view_left;
    logic signed [VIEW_W-1:0] view_top;
    logic        [DIM_W-1:0]  view_width;
    logic        [DIM_W-1:0]  view_height;
  } view_box_t;

  typedef struct packed {
    logic             in_range;
    logic [DIM_W-1:0] image_left;
    logic [DIM_W-1:0] image_top;
    logic [DIM_W-1:0] image_box_width;
    logic [DIM_W-1:0] image_box_height;
  } image_box_t;

  localparam logic signed [COEF_W-1:0]  COEF_XX_RST = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0]  COEF_XY_RST = '0;
  localparam logic signed [COEF_W-1:0]  COEF_YX_RST = '0;
  localparam logic signed [COEF_W-1:0]  COEF_YY_RST = COEF_W'(65536);
  localparam logic signed [TRANS_W-1:0] TRANS_RST   = '0;
  localparam logic        [DIM_W-1:0]   IMAGE_RST   = DIM_W'(1024);

endpackage

@@ hdl/view_box_if.sv @@
// ----------------------------------------------------------------------------
// view_box_if
// input channel: one view rectangle per beat
// ----------------------------------------------------------------------------
interface view_box_if;
  logic                               valid;
  logic                               ready;
  logic signed [vbib_pkg::VIEW_W-1:0] view_left;
  logic signed [vbib_pkg::VIEW_W-1:0] view_top;
  logic        [vbib_pkg::DIM_W-1:0]  view_width;
  logic        [vbib_pkg::DIM_W-1:0]  view_height;

  modport source (
    output valid, view_left, view_top, view_width, view_height,
    input  ready
  );
  modport sink (
    input  valid, view_left, view_top, view_width, view_height,
    output ready
  );
endinterface

@@ hdl/image_box_if.sv @@
// ----------------------------------------------------------------------------
// image_box_if
// output channel: one clipped image box per beat
// ----------------------------------------------------------------------------
interface image_box_if;
  logic                             valid;
  logic                             ready;
  logic                             in_range;
  logic [vbib_pkg::DIM_W-1:0]       image_left;
  logic [vbib_pkg::DIM_W-1:0]       image_top;
  logic [vbib_pkg::DIM_W-1:0]       image_box_width;
  logic [vbib_pkg::DIM_W-1:0]       image_box_height;

  modport source (
    output valid, in_range, image_left, image_top, image_box_width, image_box_height,
    input  ready
  );
  modport sink (
    input  valid, in_range, image_left, image_top, image_box_width, image_box_height,
    output ready
  );
endinterface

@@ hdl/view_box_to_image_box.sv @@
// ----------------------------------------------------------------------------
// view_box_to_image_box
// maps a view rectangle to the covering image box, clipped to the image
// ----------------------------------------------------------------------------
// Takes one rectangle per clock while the output is not stalled and returns
// one box per rectangle, in order. The five register stages are: corner
// expansion, matrix products, sum with floor and saturation, corner min/max,
// and clipping into the output register. Each stage moves on when the stage
// after it has room, so stalls on the output fill bubbles before they stop
// the input. Registers are written through the plain write port; the user
// must only write them while no beat is in flight; this is not enforced.
// ----------------------------------------------------------------------------
module view_box_to_image_box #(
  parameter int COORD_BITS = vbib_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vbib_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  view_box_if.sink                    box_in,
  image_box_if.source                 box_out,
  input  logic                        cfg_we_i,
  input  logic [vbib_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [vbib_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import vbib_pkg::*;

  cfg_t       cfg_q;
  view_box_t  in_box;
  image_box_t out_box;

  logic                         map_valid, map_ready;
  logic signed [COORD_BITS-1:0] ix [4];
  logic signed [COORD_BITS-1:0] iy [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_xx      <= COEF_XX_RST;
      cfg_q.coef_xy      <= COEF_XY_RST;
      cfg_q.coef_yx      <= COEF_YX_RST;
      cfg_q.coef_yy      <= COEF_YY_RST;
      cfg_q.trans_x      <= TRANS_RST;
      cfg_q.trans_y      <= TRANS_RST;
      cfg_q.image_width  <= IMAGE_RST;
      cfg_q.image_height <= IMAGE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_COEF_XX: cfg_q.coef_xx      <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_XY: cfg_q.coef_xy      <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_YX: cfg_q.coef_yx      <= cfg_wdata_i[COEF_W-1:0];
        REG_COEF_YY: cfg_q.coef_yy      <= cfg_wdata_i[COEF_W-1:0];
        REG_TRANS_X: cfg_q.trans_x      <= cfg_wdata_i[TRANS_W-1:0];
        REG_TRANS_Y: cfg_q.trans_y      <= cfg_wdata_i[TRANS_W-1:0];
        REG_IMAGE_W: cfg_q.image_width  <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_H: cfg_q.image_height <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_box.view_left   = box_in.view_left;
  assign in_box.view_top    = box_in.view_top;
  assign in_box.view_width  = box_in.view_width;
  assign in_box.view_height = box_in.view_height;

  vbib_map #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (box_in.valid),
    .ready_o (box_in.ready),
    .box_i   (in_box),
    .valid_o (map_valid),
    .ready_i (map_ready),
    .ix_o    (ix),
    .iy_o    (iy)
  );

  vbib_clip #(
    .COORD_BITS (COORD_BITS)
  ) u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (map_valid),
    .ready_o (map_ready),
    .ix_i    (ix),
    .iy_i    (iy),
    .valid_o (box_out.valid),
    .ready_i (box_out.ready),
    .box_o   (out_box)
  );

  assign box_out.in_range         = out_box.in_range;
  assign box_out.image_left       = out_box.image_left;
  assign box_out.image_top        = out_box.image_top;
  assign box_out.image_box_width  = out_box.image_box_width;
  assign box_out.image_box_height = out_box.image_box_height;

endmodule

@@ hdl/vbib_map.sv @@
// ----------------------------------------------------------------------------
// vbib_map
// corner expansion, matrix products, translation, floor and saturation
// three register stages
// ----------------------------------------------------------------------------
module vbib_map #(
  parameter int COORD_BITS = vbib_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vbib_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vbib_pkg::cfg_t               cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  vbib_pkg::view_box_t          box_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS-1:0] ix_o [4],
  output logic signed [COORD_BITS-1:0] iy_o [4]
);
  import vbib_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  function automatic logic signed [COORD_BITS-1:0] floor_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] fl;
    fl = acc >>> FRAC_BITS;
    if (fl > SAT_HI) begin
      fl = SAT_HI;
    end else if (fl < SAT_LO) begin
      fl = SAT_LO;
    end
    return fl[COORD_BITS-1:0];
  endfunction

  // stage a: corner coordinates
  logic                    va_q;
  logic signed [PIX_W-1:0] px_q [2];
  logic signed [PIX_W-1:0] py_q [2];

  // stage b: products
  logic                     vb_q;
  logic signed [PROD_W-1:0] pxx_q [2];
  logic signed [PROD_W-1:0] pyx_q [2];
  logic signed [PROD_W-1:0] pxy_q [2];
  logic signed [PROD_W-1:0] pyy_q [2];

  // stage c: floored corners
  logic                         vc_q;
  logic signed [COORD_BITS-1:0] ix_q [4];
  logic signed [COORD_BITS-1:0] iy_q [4];

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vc_q;
  assign ix_o    = ix_q;
  assign iy_o    = iy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      px_q[0] <= PIX_W'(box_i.view_left) - PIX_W'(1);
      px_q[1] <= PIX_W'(box_i.view_left) + PIX_W'({1'b0, box_i.view_width});
      py_q[0] <= PIX_W'(box_i.view_top) - PIX_W'(1);
      py_q[1] <= PIX_W'(box_i.view_top) + PIX_W'({1'b0, box_i.view_height});
    end
    if (rdy_b && va_q) begin
      for (int j = 0; j < 2; j++) begin
        pxx_q[j] <= PROD_W'(cfg_i.coef_xx) * PROD_W'(px_q[j]);
        pyx_q[j] <= PROD_W'(cfg_i.coef_yx) * PROD_W'(px_q[j]);
        pxy_q[j] <= PROD_W'(cfg_i.coef_xy) * PROD_W'(py_q[j]);
        pyy_q[j] <= PROD_W'(cfg_i.coef_yy) * PROD_W'(py_q[j]);
      end
    end
    if (rdy_c && vb_q) begin
      for (int i = 0; i < 4; i++) begin
        ix_q[i] <= floor_sat(ACC_W'(pxx_q[i[0]]) + ACC_W'(pxy_q[i[1]])
                             + ACC_W'(cfg_i.trans_x));
        iy_q[i] <= floor_sat(ACC_W'(pyx_q[i[0]]) + ACC_W'(pyy_q[i[1]])
                             + ACC_W'(cfg_i.trans_y));
      end
    end
  end

endmodule

@@ hdl/vbib_clip.sv @@
// ----------------------------------------------------------------------------
// vbib_clip
// min/max over the four corners, then clip to the image
// two register stages, the second is the output register
// ----------------------------------------------------------------------------
module vbib_clip #(
  parameter int COORD_BITS = vbib_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vbib_pkg::cfg_t               cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] ix_i [4],
  input  logic signed [COORD_BITS-1:0] iy_i [4],
  output logic                         valid_o,
  input  logic                         ready_i,
  output vbib_pkg::image_box_t         box_o
);
  import vbib_pkg::*;

  localparam int CW = ((COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1) + 1;

  function automatic logic signed [COORD_BITS-1:0] min2(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max2(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (b > a) ? b : a;
  endfunction

  logic                         vd_q;
  logic signed [COORD_BITS-1:0] x1_q, x2_q, y1_q, y2_q;

  logic       ve_q;
  image_box_t box_q;
  image_box_t box_d;

  logic rdy_d, rdy_e;

  logic signed [CW-1:0] x1, x2, y1, y2, iw, ih, cx1, cx2, cy1, cy2, bw, bh;
  logic                 hit;

  assign rdy_e   = !ve_q || ready_i;
  assign rdy_d   = !vd_q || rdy_e;
  assign ready_o = rdy_d;
  assign valid_o = ve_q;
  assign box_o   = box_q;

  always_comb begin
    x1  = CW'(x1_q);
    x2  = CW'(x2_q);
    y1  = CW'(y1_q);
    y2  = CW'(y2_q);
    iw  = $signed(CW'(cfg_i.image_width));
    ih  = $signed(CW'(cfg_i.image_height));
    hit = (iw != '0) && (ih != '0) && (x2 >= CW'(0)) && (y2 >= CW'(0))
          && (x1 < iw) && (y1 < ih);
    cx1 = (x1 < CW'(0)) ? '0 : x1;
    cy1 = (y1 < CW'(0)) ? '0 : y1;
    cx2 = (x2 >= iw) ? iw - CW'(1) : x2;
    cy2 = (y2 >= ih) ? ih - CW'(1) : y2;
    bw  = cx2 - cx1 + CW'(1);
    bh  = cy2 - cy1 + CW'(1);
    box_d = '0;
    if (hit) begin
      box_d.in_range         = 1'b1;
      box_d.image_left       = cx1[DIM_W-1:0];
      box_d.image_top        = cy1[DIM_W-1:0];
      box_d.image_box_width  = bw[DIM_W-1:0];
      box_d.image_box_height = bh[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_d) begin
        vd_q <= valid_i;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && valid_i) begin
      x1_q <= min2(min2(ix_i[0], ix_i[1]), min2(ix_i[2], ix_i[3]));
      x2_q <= max2(max2(ix_i[0], ix_i[1]), max2(ix_i[2], ix_i[3]));
      y1_q <= min2(min2(iy_i[0], iy_i[1]), min2(iy_i[2], iy_i[3]));
      y2_q <= max2(max2(iy_i[0], iy_i[1]), max2(iy_i[2], iy_i[3]));
    end
    if (rdy_e && vd_q) begin
      box_q <= box_d;
    end
  end

endmodule

@@ dv/view_box_to_image_box_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_box_to_image_box_test
// checks the view box to image box transform against a software prediction
// ----------------------------------------------------------------------------
// Drives view rectangles through the input channel and checks each clipped
// image box against a prediction computed from the current register values.
// The run steps through the reset setting, random rotated, scaled and mirrored
// settings, extreme and random register values, and an empty image, with
// random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module view_box_to_image_box_test;
  import vbib_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  SETTLE_CYCLES = 10;
  localparam longint COORD_HI = (longint'(1) << (COORD_BITS_DEF - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) << (COORD_BITS_DEF - 1));

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  class image_box_checker;
    cfg_t       cfg;
    image_box_t boxes_due[$];
    int         errors;

    function new();
      cfg.coef_xx      = COEF_XX_RST;
      cfg.coef_xy      = COEF_XY_RST;
      cfg.coef_yx      = COEF_YX_RST;
      cfg.coef_yy      = COEF_YY_RST;
      cfg.trans_x      = TRANS_RST;
      cfg.trans_y      = TRANS_RST;
      cfg.image_width  = IMAGE_RST;
      cfg.image_height = IMAGE_RST;
      errors           = 0;
    endfunction

    function longint floor_sat(longint acc);
      longint fl;
      fl = acc >>> FRAC_BITS_DEF;
      if (fl > COORD_HI) fl = COORD_HI;
      if (fl < COORD_LO) fl = COORD_LO;
      return fl;
    endfunction

    function image_box_t covering_box(view_box_t b);
      longint px[2];
      longint py[2];
      longint ix, iy, x1, x2, y1, y2, iw, ih;
      image_box_t r;
      px[0] = longint'(b.view_left) - 1;
      px[1] = longint'(b.view_left) + longint'(b.view_width);
      py[0] = longint'(b.view_top) - 1;
      py[1] = longint'(b.view_top) + longint'(b.view_height);
      x1 = 0; x2 = 0; y1 = 0; y2 = 0;
      for (int i = 0; i < 4; i++) begin
        ix = floor_sat(longint'(cfg.coef_xx) * px[i & 1] + longint'(cfg.coef_xy) * py[i >> 1]
                       + longint'(cfg.trans_x));
        iy = floor_sat(longint'(cfg.coef_yx) * px[i & 1] + longint'(cfg.coef_yy) * py[i >> 1]
                       + longint'(cfg.trans_y));
        if (i == 0 || ix < x1) x1 = ix;
        if (i == 0 || ix > x2) x2 = ix;
        if (i == 0 || iy < y1) y1 = iy;
        if (i == 0 || iy > y2) y2 = iy;
      end
      iw = longint'(cfg.image_width);
      ih = longint'(cfg.image_height);
      r = '0;
      if (iw == 0 || ih == 0 || x2 < 0 || y2 < 0 || x1 >= iw || y1 >= ih) return r;
      if (x1 < 0) x1 = 0;
      if (y1 < 0) y1 = 0;
      if (x2 >= iw) x2 = iw - 1;
      if (y2 >= ih) y2 = ih - 1;
      r.in_range         = 1'b1;
      r.image_left       = DIM_W'(x1);
      r.image_top        = DIM_W'(y1);
      r.image_box_width  = DIM_W'(x2 - x1 + 1);
      r.image_box_height = DIM_W'(y2 - y1 + 1);
      return r;
    endfunction

    function void note_view_box(view_box_t b);
      boxes_due.push_back(covering_box(b));
    endfunction

    task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_image_box(image_box_t got);
      image_box_t want;
      if (boxes_due.size() == 0) begin
        report("image box beat with none expected");
        return;
      end
      want = boxes_due.pop_front();
      if (got.in_range !== want.in_range)
        report($sformatf("in_range got %0d want %0d", got.in_range, want.in_range));
      if (got.image_left !== want.image_left)
        report($sformatf("image_left got %0d want %0d", got.image_left, want.image_left));
      if (got.image_top !== want.image_top)
        report($sformatf("image_top got %0d want %0d", got.image_top, want.image_top));
      if (got.image_box_width !== want.image_box_width)
        report($sformatf("image_box_width got %0d want %0d",
                         got.image_box_width, want.image_box_width));
      if (got.image_box_height !== want.image_box_height)
        report($sformatf("image_box_height got %0d want %0d",
                         got.image_box_height, want.image_box_height));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  view_box_if  in_if ();
  image_box_if out_if ();

  view_box_to_image_box dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_in      (in_if),
    .box_out     (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  image_box_checker book = new();
  idle_mode_e       idle_mode = IDLE_NONE;
  int               sent_count = 0;
  int               near_span = 1200;
  int               dim_cap = 300;
  int               cycles = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int idle_pct(bit recv_side);
    if (idle_mode == IDLE_BOTH) return 8;
    if (recv_side && idle_mode == IDLE_RECV) return 54;
    if (!recv_side && idle_mode == IDLE_SEND) return 54;
    return 0;
  endfunction

  function automatic view_box_t vb(int left, int top, int width, int height);
    view_box_t b;
    b.view_left   = VIEW_W'(left);
    b.view_top    = VIEW_W'(top);
    b.view_width  = DIM_W'(width);
    b.view_height = DIM_W'(height);
    return b;
  endfunction

  function automatic view_box_t rand_view_box();
    view_box_t b;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      b = vb(int'($urandom_range(2 * near_span)) - near_span,
             int'($urandom_range(2 * near_span)) - near_span,
             $urandom_range(dim_cap), $urandom_range(dim_cap));
    end else if (pick < 90) begin
      b = vb($urandom, $urandom, $urandom, $urandom);
    end else begin
      b = vb($urandom_range(1) ? -32768 : 32767, $urandom_range(1) ? -32768 : 32767,
             $urandom_range(1) ? 0 : 32767, $urandom_range(1) ? 0 : 32767);
    end
    return b;
  endfunction

  task automatic send_box(input view_box_t b);
    int gap;
    gap = 0;
    if (sent_count % 25 == 0) idle_mode = idle_mode_e'((sent_count / 25) % 4);
    while ($urandom_range(99) < idle_pct(1'b0) && gap < 40) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.view_left   <= b.view_left;
    in_if.view_top    <= b.view_top;
    in_if.view_width  <= b.view_width;
    in_if.view_height <= b.view_height;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    book.note_view_box(b);
    sent_count++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_box(rand_view_box());
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (book.boxes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input longint val);
    logic [CFG_W-1:0] data;
    data = '0;
    case (idx)
      REG_COEF_XX: begin
        data[COEF_W-1:0] = val[COEF_W-1:0];
        book.cfg.coef_xx = val[COEF_W-1:0];
      end
      REG_COEF_XY: begin
        data[COEF_W-1:0] = val[COEF_W-1:0];
        book.cfg.coef_xy = val[COEF_W-1:0];
      end
      REG_COEF_YX: begin
        data[COEF_W-1:0] = val[COEF_W-1:0];
        book.cfg.coef_yx = val[COEF_W-1:0];
      end
      REG_COEF_YY: begin
        data[COEF_W-1:0] = val[COEF_W-1:0];
        book.cfg.coef_yy = val[COEF_W-1:0];
      end
      REG_TRANS_X: begin
        data = val[TRANS_W-1:0];
        book.cfg.trans_x = val[TRANS_W-1:0];
      end
      REG_TRANS_Y: begin
        data = val[TRANS_W-1:0];
        book.cfg.trans_y = val[TRANS_W-1:0];
      end
      REG_IMAGE_W: begin
        data[DIM_W-1:0] = val[DIM_W-1:0];
        book.cfg.image_width = val[DIM_W-1:0];
      end
      default: begin
        data[DIM_W-1:0] = val[DIM_W-1:0];
        book.cfg.image_height = val[DIM_W-1:0];
      end
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // rotation by a table angle, scale, optional mirror, centered on the image
  task automatic set_affine(input bit mirror);
    longint cos_tab[6] = '{65536, 0, 46341, 39322, -52429, -65536};
    longint sin_tab[6] = '{0, 65536, 46341, 52429, 39322, 0};
    longint scale, c, s, xx, yx, w, h, reach;
    int     k;
    scale = $urandom_range(262144, 16384);
    k     = $urandom_range(5);
    c     = cos_tab[k];
    s     = sin_tab[k];
    xx    = (c * scale) >>> 16;
    yx    = (s * scale) >>> 16;
    if (mirror) begin
      xx = -xx;
      yx = -yx;
    end
    w = $urandom_range(4000, 1);
    h = $urandom_range(4000, 1);
    write_reg(REG_COEF_XX, xx);
    write_reg(REG_COEF_XY, -((s * scale) >>> 16));
    write_reg(REG_COEF_YX, yx);
    write_reg(REG_COEF_YY, (c * scale) >>> 16);
    write_reg(REG_TRANS_X, ((w / 2) << 16) + $urandom_range(65535));
    write_reg(REG_TRANS_Y, ((h / 2) << 16) + $urandom_range(65535));
    write_reg(REG_IMAGE_W, w);
    write_reg(REG_IMAGE_H, h);
    reach = ((w > h ? w : h) * 65536) / scale + 64;
    if (reach > 30000) reach = 30000;
    near_span = int'(reach);
    dim_cap   = int'(reach);
  endtask

  initial begin : image_box_sink
    image_box_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.in_range         = out_if.in_range;
        got.image_left       = out_if.image_left;
        got.image_top        = out_if.image_top;
        got.image_box_width  = out_if.image_box_width;
        got.image_box_height = out_if.image_box_height;
        book.check_image_box(got);
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  initial begin : view_box_source
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_COEF_XX;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.view_left   <= '0;
    in_if.view_top    <= '0;
    in_if.view_width  <= '0;
    in_if.view_height <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: identity, 1024 x 1024
    send_box(vb(0, 0, 0, 0));
    send_box(vb(10, 20, 30, 40));
    send_box(vb(-32768, -32768, 0, 0));
    send_box(vb(32767, 32767, 32767, 32767));
    send_box(vb(-32768, -32768, 32767, 32767));
    send_box(vb(-100, -100, 32767, 32767));
    send_box(vb(1023, 1023, 0, 0));
    send_box(vb(1024, 0, 5, 5));
    send_box(vb(1025, 0, 5, 5));
    send_box(vb(-5, -5, 3, 3));
    send_box(vb(-5, -5, 4, 4));
    send_box(vb(-5, -5, 5, 5));
    send_random(40);
    settle();

    repeat (4) begin
      set_affine(1'b0);
      send_random(80);
      settle();
    end
    repeat (2) begin
      set_affine(1'b1);
      send_random(40);
      settle();
    end

    // extreme register values, corners saturate
    write_reg(REG_COEF_XX, 8388607);
    write_reg(REG_COEF_XY, -8388608);
    write_reg(REG_COEF_YX, -8388608);
    write_reg(REG_COEF_YY, 8388607);
    write_reg(REG_TRANS_X, 2147483647);
    write_reg(REG_TRANS_Y, -2147483648);
    write_reg(REG_IMAGE_W, 32767);
    write_reg(REG_IMAGE_H, 32767);
    near_span = 300;
    dim_cap   = 300;
    send_box(vb(0, 0, 0, 0));
    send_box(vb(-32768, -32768, 32767, 32767));
    send_box(vb(32767, -32768, 0, 32767));
    send_box(vb(-1, 0, 1, 0));
    send_box(vb(100, -100, 2, 2));
    send_random(30);
    settle();

    write_reg(REG_COEF_XX, -8388608);
    write_reg(REG_COEF_XY, 8388607);
    write_reg(REG_COEF_YX, 8388607);
    write_reg(REG_COEF_YY, -8388608);
    write_reg(REG_TRANS_X, -2147483648);
    write_reg(REG_TRANS_Y, 2147483647);
    write_reg(REG_IMAGE_W, 1);
    write_reg(REG_IMAGE_H, 1);
    send_random(30);
    settle();

    // arbitrary register contents
    repeat (3) begin
      write_reg(REG_COEF_XX, $urandom);
      write_reg(REG_COEF_XY, $urandom);
      write_reg(REG_COEF_YX, $urandom);
      write_reg(REG_COEF_YY, $urandom);
      write_reg(REG_TRANS_X, $urandom);
      write_reg(REG_TRANS_Y, $urandom);
      write_reg(REG_IMAGE_W, $urandom_range(32767, 1));
      write_reg(REG_IMAGE_H, $urandom_range(32767, 1));
      near_span = 2000;
      dim_cap   = 1000;
      send_random(20);
      settle();
    end

    // empty image
    write_reg(REG_COEF_XX, 65536);
    write_reg(REG_COEF_XY, 0);
    write_reg(REG_COEF_YX, 0);
    write_reg(REG_COEF_YY, 65536);
    write_reg(REG_TRANS_X, 0);
    write_reg(REG_TRANS_Y, 0);
    write_reg(REG_IMAGE_W, 0);
    write_reg(REG_IMAGE_H, 1024);
    near_span = 1200;
    dim_cap   = 300;
    send_box(vb(0, 0, 10, 10));
    send_box(vb(-100, -100, 32767, 32767));
    send_random(15);
    settle();
    write_reg(REG_IMAGE_W, 1024);
    write_reg(REG_IMAGE_H, 0);
    send_box(vb(0, 0, 10, 10));
    send_random(15);
    settle();

    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ view_box_to_image_box.f @@
hdl/vbib_pkg.sv
hdl/view_box_if.sv
hdl/image_box_if.sv
hdl/vbib_map.sv
hdl/vbib_clip.sv
hdl/view_box_to_image_box.sv
dv/view_box_to_image_box_test.sv
